// File: hdl/psch_pkg.sv
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared sizes, the record type that moves from front to back, and states.
// ----------------------------------------------------------------------------
package psch_pkg;

  // Task capacity of one batch
  localparam int MaxTasks = 16;
  localparam int IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW     = $clog2(MaxTasks + 1);

  // Field widths
  localparam int ArrW  = 16;
  localparam int BurW  = 16;
  localparam int PriW  = 10;
  localparam int TimeW = 22;
  localparam int OutIdxW = 6;

  // Scheduling clock saturates here
  localparam logic [TimeW-1:0] ClockMax = {TimeW{1'b1}};

  // Record queue depth between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One classified record
  typedef struct packed {
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
    logic            last;
    logic            drop;
  } psch_rec_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    StLoad = 4'b0001,
    StScan = 4'b0010,
    StRun  = 4'b0100,
    StEmit = 4'b1000
  } psch_state_e;

endpackage

// File: hdl/psch_front.sv
// ----------------------------------------------------------------------------
// Priority scheduler front end
// Accepts task records and marks those beyond the batch capacity for drop.
// ----------------------------------------------------------------------------
module psch_front import psch_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ArrW-1:0] arrival_time_i,
  input  logic [BurW-1:0] burst_time_i,
  input  logic [PriW-1:0] priority_level_i,
  input  logic            last_task_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output psch_rec_t       push_rec_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drop;
  logic            beat;

  // Classify: a record past capacity is passed on marked as dropped
  assign drop = (cnt_q >= CntW'(MaxTasks));
  assign beat = in_valid_i && push_ready_i;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_rec_o   = '{arrival: arrival_time_i, burst: burst_time_i,
                          prio: priority_level_i, last: last_task_i, drop: drop};

  // Count records of the current batch, restart after the last one
  always_comb begin
    cnt_d = cnt_q;
    if (beat) begin
      if (last_task_i) begin
        cnt_d = '0;
      end else if (!drop) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/psch_queue.sv
// ----------------------------------------------------------------------------
// Priority scheduler record queue
// Short FIFO that lets the front keep taking records while the back schedules.
// ----------------------------------------------------------------------------
module psch_queue import psch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  psch_rec_t push_rec_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output psch_rec_t pop_rec_o
);

  psch_rec_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_rec_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// File: hdl/psch_back.sv
// ----------------------------------------------------------------------------
// Priority scheduler back end
// Stores a batch, runs the non-preemptive schedule and emits the results.
// ----------------------------------------------------------------------------
module psch_back import psch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  psch_rec_t          pop_rec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OutIdxW-1:0] task_index_o,
  output logic [TimeW-1:0]   turnaround_o,
  output logic [TimeW-1:0]   waiting_o,
  output logic               dropped_flag_o,
  output logic               last_result_o
);

  // Task stores
  logic [ArrW-1:0]  arr_q [MaxTasks];
  logic [BurW-1:0]  bur_q [MaxTasks];
  logic [PriW-1:0]  pri_q [MaxTasks];
  logic [TimeW-1:0] tat_q [MaxTasks];
  logic [MaxTasks-1:0] done_q, done_d;

  // Sequencer state
  psch_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  fin_q, fin_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic [IdxW-1:0]  sel_q, sel_d;
  logic [PriW-1:0]  best_q, best_d;
  logic [ArrW-1:0]  early_q, early_d;
  logic [TimeW-1:0] clk_q, clk_d;
  logic             found_q, found_d;
  logic             any_q, any_d;
  logic             ovf_q, ovf_d;

  // Output register
  logic               ov_q;
  logic [OutIdxW-1:0] oidx_q;
  logic [TimeW-1:0]   otat_q, owt_q;
  logic               odrop_q, olast_q;
  logic               out_load;

  // Single read port into the stores
  logic [IdxW-1:0]  rd_addr;
  logic [ArrW-1:0]  rd_arr;
  logic [BurW-1:0]  rd_bur;
  logic [PriW-1:0]  rd_pri;
  logic [TimeW-1:0] rd_tat;
  logic             rd_done;

  logic             pop;
  logic             store_en;
  logic             last_k;
  logic             ready_k, take_k, eupd_k;
  logic [ArrW-1:0]  early_f;
  logic [TimeW:0]   run_sum;
  logic [TimeW-1:0] run_clk, run_tat;
  logic [TimeW-1:0] emit_wt;
  logic [CntW-1:0]  fin_inc;

  assign rd_addr = (state_q == StRun) ? sel_q : k_q;
  assign rd_arr  = arr_q[rd_addr];
  assign rd_bur  = bur_q[rd_addr];
  assign rd_pri  = pri_q[rd_addr];
  assign rd_tat  = tat_q[rd_addr];
  assign rd_done = done_q[rd_addr];

  assign pop_ready_o = (state_q == StLoad);
  assign pop         = pop_valid_i && pop_ready_o;
  assign store_en    = pop && !pop_rec_i.drop && (cnt_q < CntW'(MaxTasks));

  // Scan step: ready and unfinished tests on the current task
  assign last_k  = ((CntW'(k_q) + CntW'(1)) == cnt_q);
  assign ready_k = !rd_done && (TimeW'(rd_arr) <= clk_q);
  assign take_k  = ready_k && (!found_q || (rd_pri < best_q));
  assign eupd_k  = !rd_done && (!any_q || (rd_arr < early_q));
  assign early_f = eupd_k ? rd_arr : early_q;

  // Run step: saturating clock advance and turnaround
  assign run_sum = {1'b0, clk_q} + (TimeW+1)'(rd_bur);
  assign run_clk = (run_sum > {1'b0, ClockMax}) ? ClockMax : run_sum[TimeW-1:0];
  assign run_tat = run_clk - TimeW'(rd_arr);
  assign fin_inc = fin_q + CntW'(1);

  // Emit step: waiting clamped at zero
  assign emit_wt  = (rd_tat >= TimeW'(rd_bur)) ? (rd_tat - TimeW'(rd_bur)) : '0;
  assign out_load = (state_q == StEmit) && (!ov_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    k_d     = k_q;
    sel_d   = sel_q;
    best_d  = best_q;
    early_d = early_q;
    clk_d   = clk_q;
    found_d = found_q;
    any_d   = any_q;
    ovf_d   = ovf_q;
    done_d  = done_q;
    case (state_q)
      StLoad: begin
        if (pop) begin
          if (store_en) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (pop_rec_i.drop) begin
            ovf_d = 1'b1;
          end
          if (pop_rec_i.last) begin
            state_d = StScan;
            clk_d   = '0;
            fin_d   = '0;
            k_d     = '0;
            found_d = 1'b0;
            any_d   = 1'b0;
          end
        end
      end
      StScan: begin
        if (last_k) begin
          k_d     = '0;
          found_d = 1'b0;
          any_d   = 1'b0;
          if (found_q || take_k) begin
            // pick made, run it to completion
            sel_d   = take_k ? k_q : sel_q;
            state_d = StRun;
          end else if (TimeW'(early_f) > clk_q) begin
            // idle processor: jump to earliest arrival and rescan
            clk_d = TimeW'(early_f);
          end
        end else begin
          k_d = k_q + IdxW'(1);
          if (take_k) begin
            found_d = 1'b1;
            best_d  = rd_pri;
            sel_d   = k_q;
          end
          if (eupd_k) begin
            any_d   = 1'b1;
            early_d = rd_arr;
          end
        end
      end
      StRun: begin
        clk_d         = run_clk;
        done_d[sel_q] = 1'b1;
        fin_d         = fin_inc;
        k_d           = '0;
        found_d       = 1'b0;
        any_d         = 1'b0;
        state_d       = (fin_inc == cnt_q) ? StEmit : StScan;
      end
      StEmit: begin
        if (out_load) begin
          if (last_k) begin
            state_d = StLoad;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            done_d  = '0;
            clk_d   = '0;
            k_d     = '0;
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Write the task stores
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      arr_q[cnt_q[IdxW-1:0]] <= pop_rec_i.arrival;
      bur_q[cnt_q[IdxW-1:0]] <= pop_rec_i.burst;
      pri_q[cnt_q[IdxW-1:0]] <= pop_rec_i.prio;
    end
    if (state_q == StRun) begin
      tat_q[sel_q] <= run_tat;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q  <= OutIdxW'(k_q);
      otat_q  <= rd_tat;
      owt_q   <= emit_wt;
      odrop_q <= ovf_q;
      olast_q <= last_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      fin_q   <= '0;
      k_q     <= '0;
      sel_q   <= '0;
      best_q  <= '0;
      early_q <= '0;
      clk_q   <= '0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
      ovf_q   <= 1'b0;
      done_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
      best_q  <= best_d;
      early_q <= early_d;
      clk_q   <= clk_d;
      found_q <= found_d;
      any_q   <= any_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign task_index_o   = oidx_q;
  assign turnaround_o   = otat_q;
  assign waiting_o      = owt_q;
  assign dropped_flag_o = odrop_q;
  assign last_result_o  = olast_q;

  // Batch count never passes capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTasks))
    else $error("task count above capacity");

  // A new batch loads with all done marks clear
  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> done_q == '0)
    else $error("done marks left over from previous batch");

  // The task picked to run is still unfinished
  a_run_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> !done_q[sel_q])
    else $error("finished task selected again");

  // Runs complete at most one task each and never more than stored
  a_fin_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |=> fin_q <= cnt_q)
    else $error("more tasks finished than stored");

endmodule

// File: hdl/nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Loads a batch of task records and returns turnaround and waiting per task.
// ----------------------------------------------------------------------------
// Records stream in one beat per cycle, unless the queue is full, through a
// four-entry queue; the record with last_task set closes the batch (up to 16
// stored, extras dropped and flagged). The back end then schedules the batch:
// each pick scans the N stored tasks one per cycle through a single store read
// port, then runs the pick in a run step, and an idle gap costs one extra scan;
// the results then follow in load order. Records of the next batch are taken
// while the queue has room.
module nonpreemptive_priority_scheduler import psch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ArrW-1:0]    arrival_time_i,
  input  logic [BurW-1:0]    burst_time_i,
  input  logic [PriW-1:0]    priority_level_i,
  input  logic               last_task_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OutIdxW-1:0] task_index_o,
  output logic [TimeW-1:0]   turnaround_o,
  output logic [TimeW-1:0]   waiting_o,
  output logic               dropped_flag_o,
  output logic               last_result_o
);

  logic      push_valid, push_ready;
  psch_rec_t push_rec;
  logic      pop_valid, pop_ready;
  psch_rec_t pop_rec;

  psch_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .arrival_time_i   (arrival_time_i),
    .burst_time_i     (burst_time_i),
    .priority_level_i (priority_level_i),
    .last_task_i      (last_task_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_rec_o       (push_rec)
  );

  psch_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  psch_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_rec_i      (pop_rec),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .task_index_o   (task_index_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .dropped_flag_o (dropped_flag_o),
    .last_result_o  (last_result_o)
  );

endmodule

// File: verif/nonpreemptive_priority_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler testbench
// Streams batches of task records into the scheduler and checks every
// turnaround/waiting result against a cycle-free schedule predictor. A short
// table of directed batches runs first (zero and maximum fields, an idle
// processor, priority order, ties, capacity overflow), then random batches
// with random idling on both channels.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_tb;
  import psch_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 10;
  localparam int RandomItems  = 405;
  localparam int QuietItems   = 60;
  localparam int HoldOffBatch = 12;
  localparam int DrainCycles  = 40;
  localparam int CycleLimit   = 250000;
  localparam int ReportCap    = 100;
  localparam int NumRows      = 10;

  // One result of a batch, in load order
  typedef struct packed {
    logic [OutIdxW-1:0] idx;
    logic [TimeW-1:0]   tat;
    logic [TimeW-1:0]   wt;
    logic               dropped;
    logic               last;
  } sched_result_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [ArrW-1:0]  arrival;
    logic [BurW-1:0]  burst;
    logic [PriW-1:0]  prio;
    logic             last;
    logic [4:0]       reps;
    logic             typed;
    logic [TimeW-1:0] tat;
    logic [TimeW-1:0] wt;
  } stim_row_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic [ArrW-1:0]    arrival_time_i   = '0;
  logic [BurW-1:0]    burst_time_i     = '0;
  logic [PriW-1:0]    priority_level_i = '0;
  logic               last_task_i      = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic [OutIdxW-1:0] task_index_o;
  logic [TimeW-1:0]   turnaround_o;
  logic [TimeW-1:0]   waiting_o;
  logic               dropped_flag_o;
  logic               last_result_o;

  nonpreemptive_priority_scheduler DUT (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Directed batches: single tasks at the field extremes and with an idle
  // start, priority order, a priority tie, and a batch past capacity
  stim_row_t stim_table [NumRows] = '{
    '{16'd0,     16'd0,     10'd0,    1'b1, 5'd1,  1'b1, 22'd0,     22'd0},
    '{16'hFFFF,  16'hFFFF,  10'h3FF,  1'b1, 5'd1,  1'b1, 22'd65535, 22'd0},
    '{16'd100,   16'd7,     10'd5,    1'b1, 5'd1,  1'b1, 22'd7,     22'd0},
    '{16'd0,     16'd10,    10'd9,    1'b0, 5'd1,  1'b0, 22'd0,     22'd0},
    '{16'd1,     16'd3,     10'd1,    1'b0, 5'd1,  1'b0, 22'd0,     22'd0},
    '{16'd2,     16'd4,     10'd0,    1'b1, 5'd1,  1'b0, 22'd0,     22'd0},
    '{16'd5,     16'd4,     10'd3,    1'b0, 5'd1,  1'b0, 22'd0,     22'd0},
    '{16'd5,     16'd2,     10'd3,    1'b1, 5'd1,  1'b0, 22'd0,     22'd0},
    '{16'd0,     16'd1,     10'd2,    1'b0, 5'd16, 1'b0, 22'd0,     22'd0},
    '{16'd9999,  16'd9999,  10'd1023, 1'b1, 5'd1,  1'b0, 22'd0,     22'd0}
  };

  // Schedule predictor state: the batch being loaded
  logic [ArrW-1:0] batch_arr [MaxTasks];
  logic [BurW-1:0] batch_bur [MaxTasks];
  logic [PriW-1:0] batch_pri [MaxTasks];
  int              held_cnt = 0;
  logic            lost_rec = 1'b0;

  sched_result_t   sched_results_q [$];
  sched_result_t   head_res;
  int              mismatch_cnt = 0;
  int              cycle_cnt    = 0;
  int              rx_hold      = 0;
  bit              tx_idle_en   = 1'b0;
  bit              rx_idle_en   = 1'b0;

  task automatic report_mismatch(input string what);
    // keep the log readable on a badly broken run
    if (mismatch_cnt < ReportCap) $display("MISMATCH @%0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // Arrived, unfinished task with the smallest priority; ties to lowest index
  function automatic int pick_ready(input logic [MaxTasks-1:0] done,
                                    input logic [TimeW-1:0] now);
    int sel;
    sel = -1;
    for (int k = 0; k < held_cnt; k++) begin
      if (!done[k] && TimeW'(batch_arr[k]) <= now &&
          (sel < 0 || batch_pri[k] < batch_pri[sel]))
        sel = k;
    end
    return sel;
  endfunction

  // Run the batch to completion and queue one result per stored task
  task automatic close_batch();
    logic [MaxTasks-1:0] done;
    logic [TimeW-1:0]    now;
    logic [TimeW-1:0]    tat [MaxTasks];
    logic [TimeW:0]      fin;
    logic [ArrW-1:0]     earliest;
    int                  sel;
    sched_result_t       res;
    done = '0;
    now  = '0;
    for (int n = 0; n < held_cnt; n++) begin
      sel = pick_ready(done, now);
      // processor idle: jump to the earliest pending arrival
      if (sel < 0) begin
        earliest = '1;
        for (int k = 0; k < held_cnt; k++) begin
          if (!done[k] && batch_arr[k] < earliest) earliest = batch_arr[k];
        end
        if (TimeW'(earliest) > now) now = TimeW'(earliest);
        sel = pick_ready(done, now);
      end
      // run the pick, saturating the clock
      fin = {1'b0, now} + (TimeW+1)'(batch_bur[sel]);
      now = (fin > {1'b0, ClockMax}) ? ClockMax : fin[TimeW-1:0];
      tat[sel]  = now - TimeW'(batch_arr[sel]);
      done[sel] = 1'b1;
    end
    for (int k = 0; k < held_cnt; k++) begin
      res.idx     = OutIdxW'(k);
      res.tat     = tat[k];
      res.wt      = (tat[k] >= TimeW'(batch_bur[k])) ? tat[k] - TimeW'(batch_bur[k]) : '0;
      res.dropped = lost_rec;
      res.last    = (k == held_cnt - 1);
      sched_results_q.push_back(res);
    end
    held_cnt = 0;
    lost_rec = 1'b0;
  endtask

  // Store one record, or drop it when the batch is full
  task automatic store_record(input logic [ArrW-1:0] arr, input logic [BurW-1:0] bur,
                              input logic [PriW-1:0] pri, input logic lst);
    if (held_cnt < MaxTasks) begin
      batch_arr[held_cnt] = arr;
      batch_bur[held_cnt] = bur;
      batch_pri[held_cnt] = pri;
      held_cnt++;
    end else begin
      lost_rec = 1'b1;
    end
    if (lst) close_batch();
  endtask

  // Drive one record beat and hold it until accepted
  task automatic send_record(input logic [ArrW-1:0] arr, input logic [BurW-1:0] bur,
                             input logic [PriW-1:0] pri, input logic lst);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    arrival_time_i   <= arr;
    burst_time_i     <= bur;
    priority_level_i <= pri;
    last_task_i      <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Result side: stall in random bursts while enabled
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold     = rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold     = $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result for task %0d", task_index_o));
      end else begin
        head_res = sched_results_q.pop_front();
        if (task_index_o !== head_res.idx)
          report_mismatch($sformatf("task_index %0d, want %0d", task_index_o, head_res.idx));
        if (turnaround_o !== head_res.tat)
          report_mismatch($sformatf("task %0d turnaround %0d, want %0d",
                                    head_res.idx, turnaround_o, head_res.tat));
        if (waiting_o !== head_res.wt)
          report_mismatch($sformatf("task %0d waiting %0d, want %0d",
                                    head_res.idx, waiting_o, head_res.wt));
        if (dropped_flag_o !== head_res.dropped)
          report_mismatch($sformatf("task %0d dropped_flag %b, want %b",
                                    head_res.idx, dropped_flag_o, head_res.dropped));
        if (last_result_o !== head_res.last)
          report_mismatch($sformatf("task %0d last_result %b, want %b",
                                    head_res.idx, last_result_o, head_res.last));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_cnt, sched_results_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int               rnd_items;
    int               batch_no;
    int               batch_len;
    int               arr_span;
    int               bur_span;
    int               pri_span;
    bit               quiet;
    logic [ArrW-1:0]  arr;
    logic [BurW-1:0]  bur;
    logic [PriW-1:0]  pri;
    logic             lst;
    sched_result_t    typed_res;
    rnd_items = 0;
    batch_no  = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < stim_table[r].reps; k++) begin
        lst = stim_table[r].last && (k == stim_table[r].reps - 1);
        send_record(stim_table[r].arrival, stim_table[r].burst, stim_table[r].prio, lst);
        if (stim_table[r].typed) begin
          typed_res = '{idx: '0, tat: stim_table[r].tat, wt: stim_table[r].wt,
                        dropped: 1'b0, last: 1'b1};
          sched_results_q.push_back(typed_res);
        end else begin
          store_record(stim_table[r].arrival, stim_table[r].burst, stim_table[r].prio, lst);
        end
      end
    end

    // Random batches: mostly small, some exactly full, some past capacity
    while (rnd_items < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       batch_len = $urandom_range(MaxTasks + 1, MaxTasks + 4);
        1:       batch_len = MaxTasks;
        2, 3, 4: batch_len = $urandom_range(1, 4);
        default: batch_len = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 3))
        0:       arr_span = 0;
        1:       arr_span = 20;
        2:       arr_span = 400;
        default: arr_span = 65535;
      endcase
      case ($urandom_range(0, 2))
        0:       bur_span = 15;
        1:       bur_span = 300;
        default: bur_span = 65535;
      endcase
      pri_span = ($urandom_range(0, 1) == 0) ? 3 : 1023;

      // no idling toward the end of the run
      quiet      = (rnd_items >= RandomItems - QuietItems);
      tx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
      rx_idle_en = !quiet && ($urandom_range(0, 3) != 0);

      for (int k = 0; k < batch_len; k++) begin
        arr = ArrW'($urandom_range(0, arr_span));
        bur = BurW'($urandom_range(0, bur_span));
        pri = PriW'($urandom_range(0, pri_span));
        lst = (k == batch_len - 1);
        send_record(arr, bur, pri, lst);
        store_record(arr, bur, pri, lst);
        rnd_items++;
      end
      batch_no++;

      // hold off until every outstanding result has drained
      if (batch_no == HoldOffBatch) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sched_results_q.size() != 0);
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sched_results_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/psch_pkg.sv
hdl/psch_front.sv
hdl/psch_queue.sv
hdl/psch_back.sv
hdl/nonpreemptive_priority_scheduler.sv
verif/nonpreemptive_priority_scheduler_tb.sv
